@@ src/lpht_pkg.sv @@
// Package with shared constants and controller/datapath interface types for the hash table.
`timescale 1ns / 1ps

package lpht_pkg;

   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

   typedef struct packed {
      logic accept;
      logic hash_step;
      logic start;
      logic probe;
      logic clear_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic hash_last;
      logic clear_last;
      logic probe_done;
   } sts_type;

endpackage

@@ src/lpht_dpath.sv @@
// Datapath: key hashing unit, slot memory, probe pointers and result registers.
`timescale 1ns / 1ps

module lpht_dpath #(
   parameter int SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lpht_pkg::cmd_type             cmd,
   output lpht_pkg::sts_type             sts,
   input  logic                          req_op,
   input  logic [lpht_pkg::KEY_W-1:0]    req_key,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [lpht_pkg::COUNT_W-1:0]  rsp_compare_count
);
   import lpht_pkg::*;

   localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 2);
   localparam logic [PW-1:0] LAST_POS = PW'(SLOTS - 1);
   localparam logic [CW-1:0] LAST_LAP = CW'(SLOTS - 1);
   localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             op_ff, op_in;
   logic [PW-1:0]    home;
   logic             hash_last;

   logic [PW-1:0]    pos_ff, pos_in;
   logic [PW-1:0]    eval_ff, eval_in;
   logic [CW-1:0]    lap_ff, lap_in;

   logic [KEY_W:0]   mem [SLOTS];
   logic [KEY_W:0]   rdata_ff;
   logic [PW-1:0]    raddr;
   logic             we;
   logic [PW-1:0]    waddr;
   logic [KEY_W:0]   wdata;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [PW-1:0]       res_slot_ff, res_slot_in;
   logic [CW-1:0]       res_count_ff, res_count_in;

   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [PW+SLOT_W-1:0]  slot_ext;
   logic [CW+COUNT_W-1:0] count_ext;

   logic             used;
   logic             match;
   logic             lap_last;
   logic             done;
   logic [STATUS_W-1:0] st_now;
   logic [PW-1:0]       slot_now;
   logic [CW-1:0]       count_now;

   function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
      return (p == LAST_POS) ? '0 : p + PW'(1);
   endfunction

   // Home slot: a mask for power-of-two tables, otherwise a reciprocal multiply in the
   // first hashing step and a multiply-back and subtract in the second.
   generate
      if (IS_POW2) begin : g_mask
         assign home      = key_ff[PW-1:0];
         assign hash_last = 1'b1;
      end else begin : g_recip
         // With the shift at KEY_W + PW and the multiplier rounded up, the quotient is exact
         // for every key.
         localparam int SHIFT = KEY_W + PW;
         localparam logic [KEY_W:0] RECIP =
            (KEY_W + 1)'(((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
         logic [2*KEY_W:0] prod_ff, prod_in;
         logic [KEY_W-1:0] quot;
         logic [PW-1:0]    rem_calc;
         logic [PW-1:0]    rem_ff, rem_in;
         logic             step_ff, step_in;

         assign quot     = KEY_W'(prod_ff >> SHIFT);
         assign rem_calc = PW'(key_ff - KEY_W'(quot * KEY_W'(SLOTS)));

         always_comb begin
            prod_in = prod_ff;
            rem_in  = rem_ff;
            step_in = step_ff;
            if (cmd.accept) begin
               step_in = 1'b0;
            end else if (cmd.hash_step) begin
               if (!step_ff) begin
                  prod_in = (2*KEY_W+1)'(key_ff) * (2*KEY_W+1)'(RECIP);
                  step_in = 1'b1;
               end else begin
                  rem_in = rem_calc;
               end
            end
         end

         always_ff @(posedge clock) begin
            prod_ff <= prod_in;
            rem_ff  <= rem_in;
            step_ff <= step_in;
         end

         assign home      = rem_ff;
         assign hash_last = step_ff;
      end
   endgenerate

   assign key_in = cmd.accept ? req_key : key_ff;
   assign op_in  = cmd.accept ? req_op  : op_ff;

   // Evaluation of the slot whose word is in the read register.
   always_comb begin
      used      = rdata_ff[KEY_W];
      match     = (rdata_ff[KEY_W-1:0] == key_ff);
      lap_last  = (lap_ff == LAST_LAP);
      slot_now  = '0;
      count_now = '0;
      if (op_ff == OP_INSERT) begin
         done   = !used || lap_last;
         st_now = used ? ST_FULL : ST_INSERTED;
         if (!used) begin
            slot_now = eval_ff;
         end
      end else begin
         done = !used || match || lap_last;
         if (used && match) begin
            st_now    = ST_FOUND;
            slot_now  = eval_ff;
            count_now = lap_ff + CW'(1);
         end else if (!used) begin
            st_now    = ST_MISSING;
            count_now = lap_ff + CW'(1);
         end else begin
            // Whole lap of occupied slots without a match.
            st_now    = ST_MISSING;
            count_now = lap_ff + CW'(2);
         end
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      eval_in = eval_ff;
      lap_in  = lap_ff;
      if (cmd.clear_step) begin
         pos_in = next_pos(pos_ff);
      end else if (cmd.start) begin
         pos_in  = next_pos(home);
         eval_in = home;
         lap_in  = '0;
      end else if (cmd.probe) begin
         pos_in  = next_pos(pos_ff);
         eval_in = pos_ff;
         lap_in  = lap_ff + CW'(1);
      end
   end

   assign raddr = cmd.start ? home : pos_ff;

   always_comb begin
      we    = 1'b0;
      waddr = pos_ff;
      wdata = '0;
      if (cmd.clear_step) begin
         we = 1'b1;
      end else if (cmd.probe && op_ff == OP_INSERT && !used) begin
         we    = 1'b1;
         waddr = eval_ff;
         wdata = {1'b1, key_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign res_status_in = (cmd.probe && done) ? st_now    : res_status_ff;
   assign res_slot_in   = (cmd.probe && done) ? slot_now  : res_slot_ff;
   assign res_count_in  = (cmd.probe && done) ? count_now : res_count_ff;

   assign slot_ext  = {{SLOT_W{1'b0}}, res_slot_ff};
   assign count_ext = {{COUNT_W{1'b0}}, res_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
      key_ff        <= key_in;
      op_ff         <= op_in;
      eval_ff       <= eval_in;
      lap_ff        <= lap_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_count_ff  <= res_count_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= slot_ext[SLOT_W-1:0];
         rsp_count_ff  <= count_ext[COUNT_W-1:0];
      end
   end

   assign sts.hash_last  = hash_last;
   assign sts.clear_last = (pos_ff == LAST_POS);
   assign sts.probe_done = done;

   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_compare_count = rsp_count_ff;

endmodule

@@ src/lpht_ctrl.sv @@
// Controller: sequences the clearing pass, hashing, probing and result hand-off.
`timescale 1ns / 1ps

module lpht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpht_pkg::cmd_type cmd,
   input  lpht_pkg::sts_type sts
);
   import lpht_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_START  = 3'd3;
   localparam logic [2:0] S_PROBE  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_last) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = S_PROBE;
         end
         S_PROBE: begin
            cmd.probe = 1'b1;
            if (sts.probe_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // The result waits here until the output register is free.
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/linear_probe_hash_table_core.sv @@
// Linear-probing hash table: an insert or a search is accepted, hashed (a mask for a power-of-two
// SLOTS, else a reciprocal multiply), then probed at one slot per cycle, 1..SLOTS probes, through
// the single read port of the slot memory, and its result is registered for hand-off.
// One transaction is in flight at a time; a new one is taken while the previous result waits,
// and a stalled result holds the next back.
// After reset a clearing pass empties every slot before the first transaction.
`timescale 1ns / 1ps

module linear_probe_hash_table_core #(
   parameter int SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [lpht_pkg::KEY_W-1:0]    req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [lpht_pkg::COUNT_W-1:0]  rsp_compare_count
);
   import lpht_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   lpht_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_op),
      .req_key           (req_key),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_compare_count (rsp_compare_count)
   );

endmodule

@@ src/lpht_checker.sv @@
// Port-level checker for the hash table core and its bind statement.
`timescale 1ns / 1ps

module lpht_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   input logic [lpht_pkg::SLOT_W-1:0]   rsp_slot,
   input logic [lpht_pkg::COUNT_W-1:0]  rsp_compare_count
);
   import lpht_pkg::*;

   // A stalled result transaction holds its valid and payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
         && $stable(rsp_compare_count))
      else $error("stalled result changed");

   a_insert_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_INSERTED || rsp_status == ST_FULL)
         |-> rsp_compare_count == '0)
      else $error("insert reported comparisons");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_MISSING) |-> rsp_slot == '0)
      else $error("failed transaction reported a slot");

   a_search_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FOUND || rsp_status == ST_MISSING)
         |-> rsp_compare_count != '0)
      else $error("search reported no comparisons");

   // While reset is held, the core keeps the input stalled and shows no valid result.
   a_reset_stall: assert property (@(posedge clock)
      $past(reset) && reset |-> req_stall && !rsp_valid)
      else $error("core not held after reset");

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_slot          (rsp_slot),
   .rsp_compare_count (rsp_compare_count)
);
